// ----- rtl/core/ncmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncmc_pkg
// Shared constants and types of the nearest-centroid moment classifier.
// ----------------------------------------------------------------------------
package ncmc_pkg;

  localparam int NUM_CLASSES_DEF = 9;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int NUM_MOMENTS = 7;
  localparam int MOMENT_W    = 24;
  localparam int LABEL_W     = 4;
  localparam int DIGIT_W     = 4;
  localparam int SQ_W        = 2 * MOMENT_W + 2;
  localparam int SUM_W       = SQ_W + 3;
  localparam int QUOT_W      = MOMENT_W;
  localparam int BIT_W       = $clog2(QUOT_W);
  localparam int S_DATA_W    = ((NUM_MOMENTS * MOMENT_W + LABEL_W + 7) / 8) * 8;
  localparam int M_DATA_W    = ((DIGIT_W + 7) / 8) * 8;

  typedef struct packed {
    logic             load;
    logic             mul;
    logic             dinit;
    logic             dstep;
    logic [BIT_W-1:0] bit_idx;
    logic             write;
  } lane_ctrl_t;

endpackage

// ----- rtl/core/nearest_centroid_moment_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_moment_classifier
// Nearest-centroid digit classifier over seven moments, with running-mean
// training.
// ----------------------------------------------------------------------------
// Input beats on s_* carry seven signed Q3.20 moments and a label; result
// beats on m_* carry the digit. cfg_we/cfg_wdata set train_en; it is to be
// written only while idle by the user, as the block does not enforce it.
// One item at a time. Classify: seven lanes square the distance to one class
// per cycle, the merge stage sums and compares, and the result is taken once
// the merge has seen the last class. Train: a multiply step, a setup step, a
// bit-serial divide of the 24-bit quotient and a write; a label of zero or
// beyond the classes skips the update and is echoed back as the digit.
// s_tready is high only while no item is in flight. A finished result sits
// in the output register; a stalled receiver holds it there and the next
// item may be accepted, but that item's result waits until the register
// frees. Reset clears all centroids, counts and train_en.
// ----------------------------------------------------------------------------
module nearest_centroid_moment_classifier #(
  parameter int NUM_CLASSES = ncmc_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_WIDTH = ncmc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // moment_02, moment_03, moment_11, moment_12, moment_20, moment_21,
  // moment_30, true_label
  input  logic [ncmc_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // digit
  output logic [ncmc_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata
);
  import ncmc_pkg::*;

  localparam int CLS_W = $clog2(NUM_CLASSES);

  typedef enum logic [2:0] {IDLE, DIST, DWAIT, TMUL, TDINIT, TDIV, TWRITE, FINISH} state_t;

  state_t                 state;
  logic                   train_en;
  logic [CLS_W-1:0]       cls;
  logic [BIT_W-1:0]       bit_idx;
  logic [DIGIT_W-1:0]     result;
  logic [DIGIT_W-1:0]     result_out;
  logic [COUNT_WIDTH-1:0] counts [NUM_CLASSES];
  logic [COUNT_WIDTH-1:0] cnt_sel;
  logic [LABEL_W-1:0]     label;
  logic                   accept;
  logic                   label_ok;
  lane_ctrl_t             ctrl;
  logic [SQ_W-1:0]        sq [NUM_MOMENTS];
  logic                   merge_done;
  logic [CLS_W-1:0]       best_cls;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign label    = s_tdata[NUM_MOMENTS*MOMENT_W +: LABEL_W];
  assign label_ok = (label != '0) && (32'(label) <= NUM_CLASSES);
  assign cnt_sel  = counts[cls];
  assign m_tdata  = M_DATA_W'(result_out);

  always_comb begin
    ctrl         = '0;
    ctrl.load    = accept;
    ctrl.mul     = (state == TMUL);
    ctrl.dinit   = (state == TDINIT);
    ctrl.dstep   = (state == TDIV);
    ctrl.bit_idx = bit_idx;
    ctrl.write   = (state == TWRITE);
  end

  for (genvar g = 0; g < NUM_MOMENTS; g++) begin : g_lane
    ncmc_lane #(
      .NUM_CLASSES(NUM_CLASSES),
      .COUNT_WIDTH(COUNT_WIDTH),
      .CLS_W      (CLS_W)
    ) u_lane (
      .clk (clk),
      .rst (rst),
      .ctrl(ctrl),
      .cls (cls),
      .cnt (cnt_sel),
      .x_in(s_tdata[g*MOMENT_W +: MOMENT_W]),
      .sq  (sq[g])
    );
  end

  ncmc_merge #(
    .NUM_CLASSES(NUM_CLASSES),
    .CLS_W      (CLS_W)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .issue_valid(state == DIST),
    .issue_cls  (cls),
    .sq         (sq),
    .done       (merge_done),
    .best_cls   (best_cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      train_en <= 1'b0;
      m_tvalid <= 1'b0;
      cls      <= '0;
      bit_idx  <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) counts[i] <= '0;
    end else begin
      if (cfg_we) train_en <= cfg_wdata;
      if (state == FINISH && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (train_en) begin
              result <= DIGIT_W'(label);
              cls    <= CLS_W'(label - 1'b1);
              state  <= label_ok ? TMUL : FINISH;
            end else begin
              cls   <= '0;
              state <= DIST;
            end
          end
        end
        DIST: begin
          if (32'(cls) == NUM_CLASSES - 1) state <= DWAIT;
          else cls <= cls + 1'b1;
        end
        DWAIT: begin
          if (merge_done) begin
            result <= DIGIT_W'({1'b0, best_cls} + 1'b1);
            state  <= FINISH;
          end
        end
        TMUL: state <= TDINIT;
        TDINIT: begin
          bit_idx <= BIT_W'(QUOT_W - 1);
          state   <= TDIV;
        end
        TDIV: begin
          if (bit_idx == '0) state <= TWRITE;
          else bit_idx <= bit_idx - 1'b1;
        end
        TWRITE: begin
          if (cnt_sel != '1) counts[cls] <= cnt_sel + 1'b1;
          state <= FINISH;
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            result_out <= result;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/ncmc_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncmc_lane
// One moment lane: holds this moment of every centroid, squares the distance
// to the selected class, and runs the running-mean update with a
// bit-per-cycle divider.
// ----------------------------------------------------------------------------
module ncmc_lane #(
  parameter int NUM_CLASSES = ncmc_pkg::NUM_CLASSES_DEF,
  parameter int COUNT_WIDTH = ncmc_pkg::COUNT_WIDTH_DEF,
  parameter int CLS_W       = $clog2(NUM_CLASSES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ncmc_pkg::lane_ctrl_t        ctrl,
  input  logic [CLS_W-1:0]            cls,
  input  logic [COUNT_WIDTH-1:0]      cnt,
  input  logic [ncmc_pkg::MOMENT_W-1:0] x_in,
  output logic [ncmc_pkg::SQ_W-1:0]   sq
);
  import ncmc_pkg::*;

  localparam int NUM_W = MOMENT_W + COUNT_WIDTH + 2;

  logic signed [MOMENT_W-1:0]      cen [NUM_CLASSES];
  logic signed [MOMENT_W-1:0]      x;
  logic signed [MOMENT_W-1:0]      mean;
  logic signed [MOMENT_W:0]        diff;
  logic signed [COUNT_WIDTH:0]     cnt_s;
  logic signed [MOMENT_W+COUNT_WIDTH:0] prod;
  logic signed [NUM_W-1:0]         num;
  logic        [NUM_W-1:0]         rem;
  logic        [NUM_W-1:0]         dsh;
  logic        [COUNT_WIDTH:0]     divisor;
  logic        [QUOT_W-1:0]        quot;
  logic                            neg;

  assign mean    = cen[cls];
  assign diff    = (MOMENT_W+1)'(x) - (MOMENT_W+1)'(mean);
  assign cnt_s   = $signed({1'b0, cnt});
  assign prod    = mean * cnt_s;
  assign divisor = (COUNT_WIDTH+1)'(cnt) + 1'b1;
  assign dsh     = NUM_W'(divisor) << ctrl.bit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) cen[i] <= '0;
    end else if (ctrl.write) begin
      cen[cls] <= neg ? MOMENT_W'(-quot) : MOMENT_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) x <= x_in;
    sq <= SQ_W'(diff * diff);
    if (ctrl.mul) num <= NUM_W'(prod) + NUM_W'(x);
    if (ctrl.dinit) begin
      neg  <= num[NUM_W-1];
      rem  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      quot <= '0;
    end else if (ctrl.dstep && rem >= dsh) begin
      rem               <= rem - dsh;
      quot[ctrl.bit_idx] <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/ncmc_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncmc_merge
// Sums the lane squares of one class and keeps the running minimum,
// lowest class winning ties.
// ----------------------------------------------------------------------------
module ncmc_merge #(
  parameter int NUM_CLASSES = ncmc_pkg::NUM_CLASSES_DEF,
  parameter int CLS_W       = $clog2(NUM_CLASSES)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      issue_valid,
  input  logic [CLS_W-1:0]          issue_cls,
  input  logic [ncmc_pkg::SQ_W-1:0] sq [ncmc_pkg::NUM_MOMENTS],
  output logic                      done,
  output logic [CLS_W-1:0]          best_cls
);
  import ncmc_pkg::*;

  logic             va, vb;
  logic [CLS_W-1:0] ca, cb;
  logic [SUM_W-1:0] sum, best, sum_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < NUM_MOMENTS; i++) sum_next = sum_next + SUM_W'(sq[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vb   <= 1'b0;
      done <= 1'b0;
    end else begin
      va   <= issue_valid;
      vb   <= va;
      done <= vb && (32'(cb) == NUM_CLASSES - 1);
    end
    ca  <= issue_cls;
    cb  <= ca;
    sum <= sum_next;
    if (vb && (cb == '0 || sum < best)) begin
      best     <= sum;
      best_cls <= cb;
    end
  end

endmodule
